@@ design/hermitian_eigen_cofactors_defines.svh @@
// ----------------------------------------------------------------------------
// hermitian_eigen_cofactors_defines
// assertion macros shared by the cofactor block
// ----------------------------------------------------------------------------
`ifndef HERMITIAN_EIGEN_COFACTORS_DEFINES_SVH
`define HERMITIAN_EIGEN_COFACTORS_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define HEC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hec: same-cycle check failed");

// next-cycle implication, clocked on clock, off during reset
`define HEC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hec: next-cycle check failed");

`endif

@@ design/hec_pkg.sv @@
// ----------------------------------------------------------------------------
// hec_pkg
// types and constants for the shifted hermitian cofactor block
// ----------------------------------------------------------------------------
`default_nettype none

package hec_pkg;

   // field and datapath widths
   localparam int IN_W   = 32;
   localparam int OP_W   = IN_W + 1;     // shifted diagonal or conjugated part
   localparam int PROD_W = 2 * OP_W;     // one full product
   localparam int SUM_W  = PROD_W + 2;   // sum of three products
   localparam int OUT_W  = 64;
   localparam int IDX_W  = 2;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // cofactor row codes and last eigenvalue index
   localparam logic [IDX_W-1:0] ROW_E    = 2'd0;
   localparam logic [IDX_W-1:0] ROW_MU   = 2'd1;
   localparam logic [IDX_W-1:0] ROW_TAU  = 2'd2;
   localparam logic [IDX_W-1:0] EIG_LAST = 2'd2;

   typedef struct packed {
      logic signed [IN_W-1:0] diag_e;
      logic signed [IN_W-1:0] diag_mu;
      logic signed [IN_W-1:0] diag_tau;
      logic signed [IN_W-1:0] off_emu_re;
      logic signed [IN_W-1:0] off_emu_im;
      logic signed [IN_W-1:0] off_etau_re;
      logic signed [IN_W-1:0] off_etau_im;
      logic signed [IN_W-1:0] off_mutau_re;
      logic signed [IN_W-1:0] off_mutau_im;
      logic signed [IN_W-1:0] eigen_0;
      logic signed [IN_W-1:0] eigen_1;
      logic signed [IN_W-1:0] eigen_2;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]        eigen_index;
      logic [IDX_W-1:0]        row_index;
      logic signed [OUT_W-1:0] col0_re;
      logic signed [OUT_W-1:0] col0_im;
      logic signed [OUT_W-1:0] col1_re;
      logic signed [OUT_W-1:0] col1_im;
      logic signed [OUT_W-1:0] col2_re;
      logic signed [OUT_W-1:0] col2_im;
      logic                    saturated;
      logic                    last;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [OP_W-1:0] re;
      logic signed [OP_W-1:0] im;
   } cplx_type;

   // operands of one cofactor: p*q - r*s, diag forces the imaginary part to zero
   typedef struct packed {
      logic signed [OP_W-1:0] p_re;
      logic signed [OP_W-1:0] p_im;
      logic signed [OP_W-1:0] q_re;
      logic signed [OP_W-1:0] q_im;
      logic signed [OP_W-1:0] r_re;
      logic signed [OP_W-1:0] r_im;
      logic signed [OP_W-1:0] s;
      logic                   diag;
   } cof_op_type;

   // clipped cofactor leaving the arithmetic unit
   typedef struct packed {
      logic signed [OUT_W-1:0] re;
      logic signed [OUT_W-1:0] im;
      logic                    sat;
   } cof_res_type;

   // tag that travels with each row through the pipeline
   typedef struct packed {
      logic [IDX_W-1:0] eigen_index;
      logic [IDX_W-1:0] row_index;
      logic             last;
   } row_tag_type;

endpackage

`default_nettype wire

@@ design/hec_cofactor.sv @@
// ----------------------------------------------------------------------------
// hec_cofactor
// one complex cofactor p*q - r*s: product stage, sum stage, clipping to 64 bits
// ----------------------------------------------------------------------------
`default_nettype none

module hec_cofactor
   import hec_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  cof_op_type  op,
   output cof_res_type res
);

   logic signed [PROD_W-1:0] prod_ff [6];
   logic signed [PROD_W-1:0] prod_in [6];
   logic                     diag_ff;
   logic signed [SUM_W-1:0]  re_ff;
   logic signed [SUM_W-1:0]  re_in;
   logic signed [SUM_W-1:0]  im_ff;
   logic signed [SUM_W-1:0]  im_in;

   function automatic logic fits_out(input logic signed [SUM_W-1:0] v);
      return (v[SUM_W-1:OUT_W-1] == '0) || (v[SUM_W-1:OUT_W-1] == '1);
   endfunction

   function automatic logic signed [OUT_W-1:0] clip(input logic signed [SUM_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (fits_out(v)) begin
         r = v[OUT_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = OUT_MIN;
      end else begin
         r = OUT_MAX;
      end
      return r;
   endfunction

   // six partial products
   always_comb begin
      prod_in[0] = PROD_W'(op.p_re) * PROD_W'(op.q_re);
      prod_in[1] = PROD_W'(op.p_im) * PROD_W'(op.q_im);
      prod_in[2] = PROD_W'(op.r_re) * PROD_W'(op.s);
      prod_in[3] = PROD_W'(op.p_re) * PROD_W'(op.q_im);
      prod_in[4] = PROD_W'(op.p_im) * PROD_W'(op.q_re);
      prod_in[5] = PROD_W'(op.r_im) * PROD_W'(op.s);
   end

   // combine into real and imaginary parts
   always_comb begin
      re_in = SUM_W'(prod_ff[0]) - SUM_W'(prod_ff[1]) - SUM_W'(prod_ff[2]);
      if (diag_ff) begin
         im_in = '0;
      end else begin
         im_in = SUM_W'(prod_ff[3]) + SUM_W'(prod_ff[4]) - SUM_W'(prod_ff[5]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         diag_ff <= op.diag;
         re_ff   <= re_in;
         im_ff   <= im_in;
      end
   end

   // clip to the output range
   always_comb begin
      res.re  = clip(re_ff);
      res.im  = clip(im_ff);
      res.sat = !fits_out(re_ff) || !fits_out(im_ff);
   end

endmodule

`default_nettype wire

@@ design/hermitian_eigen_cofactors.sv @@
// pipeline: item register, then operand, product, sum and output registers per row
// throughput: one row per cycle while the output is not stalled, nine rows per
//   transaction, set by the row sequencer feeding the three cofactor units
// a new transaction is taken in the cycle the previous one issues its last row
// synchronous reset clears the sequencer and all stage valid bits
// ----------------------------------------------------------------------------
// hermitian_eigen_cofactors
// cofactors of H - kI for a 3x3 hermitian matrix and three eigenvalues
// ----------------------------------------------------------------------------
`default_nettype none

`include "hermitian_eigen_cofactors_defines.svh"

module hermitian_eigen_cofactors
   import hec_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic             en;
   logic             accept;
   logic             issue_last;

   req_payload_type  item_ff;
   req_payload_type  item_in;
   logic             hold_ff;
   logic             hold_in;
   logic [IDX_W-1:0] eig_ff;
   logic [IDX_W-1:0] eig_in;
   logic [IDX_W-1:0] row_ff;
   logic [IDX_W-1:0] row_in;

   logic             v1_ff;
   logic             v2_ff;
   logic             v3_ff;
   row_tag_type      tag1_ff;
   row_tag_type      tag1_in;
   row_tag_type      tag2_ff;
   row_tag_type      tag3_ff;
   cof_op_type       op_ff [3];
   cof_op_type       op_in [3];
   cof_res_type      res [3];

   logic             rsp_valid_ff;
   rsp_payload_type  rsp_payload_ff;
   rsp_payload_type  rsp_payload_in;

   cplx_type               a;
   cplx_type               b;
   cplx_type               c;
   logic signed [OP_W-1:0] k;
   logic signed [OP_W-1:0] de;
   logic signed [OP_W-1:0] dm;
   logic signed [OP_W-1:0] dt;

   function automatic cplx_type conj(input cplx_type x);
      cplx_type r;
      r.re = x.re;
      r.im = -x.im;
      return r;
   endfunction

   function automatic cof_op_type mk_off(input cplx_type p, input cplx_type q,
                                         input cplx_type r, input logic signed [OP_W-1:0] s);
      cof_op_type o;
      o.p_re = p.re;
      o.p_im = p.im;
      o.q_re = q.re;
      o.q_im = q.im;
      o.r_re = r.re;
      o.r_im = r.im;
      o.s    = s;
      o.diag = 1'b0;
      return o;
   endfunction

   // d1*d2 - im^2 - re^2 through the same product form
   function automatic cof_op_type mk_diag(input logic signed [OP_W-1:0] d1,
                                          input logic signed [OP_W-1:0] d2,
                                          input cplx_type x);
      cof_op_type o;
      o.p_re = d1;
      o.p_im = x.im;
      o.q_re = d2;
      o.q_im = x.im;
      o.r_re = x.re;
      o.r_im = '0;
      o.s    = x.re;
      o.diag = 1'b1;
      return o;
   endfunction

   // pipeline advance and input handshake
   assign en         = !rsp_valid_ff || !rsp_stall;
   assign issue_last = (eig_ff == EIG_LAST) && (row_ff == ROW_TAU);
   assign req_stall  = hold_ff && !(en && issue_last);
   assign accept     = req_valid && !req_stall;

   // item holding register and row sequencer
   always_comb begin
      item_in = accept ? req_payload : item_ff;
      hold_in = hold_ff;
      eig_in  = eig_ff;
      row_in  = row_ff;
      if (en && hold_ff) begin
         if (row_ff == ROW_TAU) begin
            row_in = ROW_E;
            eig_in = issue_last ? '0 : eig_ff + 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
         if (issue_last) begin
            hold_in = 1'b0;
         end
      end
      if (accept) begin
         hold_in = 1'b1;
      end
   end

   // off-diagonal entries and shifted diagonal entries for the current eigenvalue
   always_comb begin
      a.re = OP_W'(item_ff.off_emu_re);
      a.im = OP_W'(item_ff.off_emu_im);
      b.re = OP_W'(item_ff.off_etau_re);
      b.im = OP_W'(item_ff.off_etau_im);
      c.re = OP_W'(item_ff.off_mutau_re);
      c.im = OP_W'(item_ff.off_mutau_im);
      unique case (eig_ff)
         2'd0:    k = OP_W'(item_ff.eigen_0);
         2'd1:    k = OP_W'(item_ff.eigen_1);
         default: k = OP_W'(item_ff.eigen_2);
      endcase
      de = OP_W'(item_ff.diag_e) - k;
      dm = OP_W'(item_ff.diag_mu) - k;
      dt = OP_W'(item_ff.diag_tau) - k;
   end

   // operand selection for the three columns of this row
   always_comb begin
      unique case (row_ff)
         ROW_E: begin
            op_in[0] = mk_diag(dm, dt, c);
            op_in[1] = mk_off(c, conj(b), conj(a), dt);
            op_in[2] = mk_off(conj(c), conj(a), conj(b), dm);
         end
         ROW_MU: begin
            op_in[0] = mk_off(b, conj(c), a, dt);
            op_in[1] = mk_diag(de, dt, b);
            op_in[2] = mk_off(conj(b), a, conj(c), de);
         end
         default: begin
            op_in[0] = mk_off(a, c, b, dm);
            op_in[1] = mk_off(conj(a), b, c, de);
            op_in[2] = mk_diag(de, dm, a);
         end
      endcase
      tag1_in.eigen_index = eig_ff;
      tag1_in.row_index   = row_ff;
      tag1_in.last        = issue_last;
   end

   // three cofactor units, one per column
   for (genvar i = 0; i < 3; i++) begin : g_col
      hec_cofactor u_cof (
         .clock (clock),
         .en    (en),
         .op    (op_ff[i]),
         .res   (res[i])
      );
   end

   // output row assembly
   always_comb begin
      rsp_payload_in.eigen_index = tag3_ff.eigen_index;
      rsp_payload_in.row_index   = tag3_ff.row_index;
      rsp_payload_in.col0_re     = res[0].re;
      rsp_payload_in.col0_im     = res[0].im;
      rsp_payload_in.col1_re     = res[1].re;
      rsp_payload_in.col1_im     = res[1].im;
      rsp_payload_in.col2_re     = res[2].re;
      rsp_payload_in.col2_im     = res[2].im;
      rsp_payload_in.saturated   = res[0].sat || res[1].sat || res[2].sat;
      rsp_payload_in.last        = tag3_ff.last;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= 1'b0;
         eig_ff       <= '0;
         row_ff       <= ROW_E;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
         eig_ff  <= eig_in;
         row_ff  <= row_in;
         if (en) begin
            v1_ff        <= hold_ff;
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (en) begin
         op_ff          <= op_in;
         tag1_ff        <= tag1_in;
         tag2_ff        <= tag1_ff;
         tag3_ff        <= tag2_ff;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   `HEC_ASSERT_IMPL(a_last_tag, rsp_valid_ff && rsp_payload_ff.last, rsp_payload_ff.row_index == ROW_TAU && rsp_payload_ff.eigen_index == EIG_LAST)
   `HEC_ASSERT_IMPL(a_diag_im_zero, rsp_valid_ff, (rsp_payload_ff.row_index == ROW_E && rsp_payload_ff.col0_im == '0) || (rsp_payload_ff.row_index == ROW_MU && rsp_payload_ff.col1_im == '0) || (rsp_payload_ff.row_index == ROW_TAU && rsp_payload_ff.col2_im == '0))
   `HEC_ASSERT_NEXT(a_drain, en && hold_ff && issue_last && !accept, !hold_ff)
   `HEC_ASSERT_IMPL(a_idle_counts, !hold_ff, eig_ff == '0 && row_ff == ROW_E)

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the shifted hermitian cofactor block
// each matrix transaction expands into its nine predicted cofactor rows,
// exact 80-bit arithmetic clipped to 64 bits, checked in order field by field
// directed extremes first, then random matrices under several idle and stall
// mixes, including a long result hold-off that backs up the input
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import hec_pkg::*;

   localparam int ACC_W            = 80;
   localparam int RESET_CYCLES     = 11;
   localparam int ITEMS_PER_PHASE  = 38;
   localparam int NUM_PHASES       = 5;
   localparam int PRESSURE_PHASE   = 4;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int REPORT_LIMIT     = 10;

   localparam logic [IN_W-1:0] IN_MAX = 32'h7fff_ffff;
   localparam logic [IN_W-1:0] IN_MIN = 32'h8000_0000;

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef struct {
      acc_type re;
      acc_type im;
   } cval_type;

   // how the fields of a random matrix are drawn
   typedef enum int {VAL_SMALL, VAL_FULL, VAL_EXTREME, VAL_MIXED} value_style_type;

   // --------------------------------------------------------------------------
   // scoreboard: predicts cofactor rows and checks them in order
   // --------------------------------------------------------------------------
   class cofactor_scoreboard;
      rsp_payload_type expected_rows[$];
      int mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("cofactor mismatch: %s", msg);
      endfunction

      function logic signed [OUT_W-1:0] clip64(acc_type v, inout bit sat);
         if (v > acc_type'(OUT_MAX)) begin
            sat = 1'b1;
            return OUT_MAX;
         end
         if (v < acc_type'(OUT_MIN)) begin
            sat = 1'b1;
            return OUT_MIN;
         end
         return v[OUT_W-1:0];
      endfunction

      function cval_type conj_of(cval_type x);
         cval_type y;
         y.re = x.re;
         y.im = -x.im;
         return y;
      endfunction

      // p*q - r*s with s real
      function void off_cof(cval_type p, cval_type q, cval_type r, acc_type s,
                            output logic signed [OUT_W-1:0] re,
                            output logic signed [OUT_W-1:0] im, inout bit sat);
         acc_type sum_re, sum_im;
         sum_re = p.re * q.re - p.im * q.im - r.re * s;
         sum_im = p.re * q.im + p.im * q.re - r.im * s;
         re = clip64(sum_re, sat);
         im = clip64(sum_im, sat);
      endfunction

      // d1*d2 - |c|^2, imaginary part always zero
      function void diag_cof(acc_type d1, acc_type d2, cval_type c,
                             output logic signed [OUT_W-1:0] re,
                             output logic signed [OUT_W-1:0] im, inout bit sat);
         acc_type sum_re;
         sum_re = d1 * d2 - c.re * c.re - c.im * c.im;
         re = clip64(sum_re, sat);
         im = '0;
      endfunction

      // expand one accepted matrix transaction into its nine rows
      function void note_matrix(req_payload_type m);
         logic [IDX_W-1:0] row_codes[3];
         logic signed [IN_W-1:0] eig[3];
         acc_type he, hm, ht, k, de, dm, dt;
         cval_type a, b, c;
         rsp_payload_type r;
         bit sat;
         row_codes = '{ROW_E, ROW_MU, ROW_TAU};
         eig = '{m.eigen_0, m.eigen_1, m.eigen_2};
         he = $signed(m.diag_e);
         hm = $signed(m.diag_mu);
         ht = $signed(m.diag_tau);
         a.re = $signed(m.off_emu_re);
         a.im = $signed(m.off_emu_im);
         b.re = $signed(m.off_etau_re);
         b.im = $signed(m.off_etau_im);
         c.re = $signed(m.off_mutau_re);
         c.im = $signed(m.off_mutau_im);
         for (int j = 0; j < 3; j++) begin
            k = $signed(eig[j]);
            de = he - k;
            dm = hm - k;
            dt = ht - k;
            for (int row = 0; row < 3; row++) begin
               sat = 1'b0;
               r = '0;
               case (row_codes[row])
                  ROW_E: begin
                     diag_cof(dm, dt, c, r.col0_re, r.col0_im, sat);
                     off_cof(c, conj_of(b), conj_of(a), dt, r.col1_re, r.col1_im, sat);
                     off_cof(conj_of(c), conj_of(a), conj_of(b), dm,
                             r.col2_re, r.col2_im, sat);
                  end
                  ROW_MU: begin
                     off_cof(b, conj_of(c), a, dt, r.col0_re, r.col0_im, sat);
                     diag_cof(de, dt, b, r.col1_re, r.col1_im, sat);
                     off_cof(conj_of(b), a, conj_of(c), de, r.col2_re, r.col2_im, sat);
                  end
                  default: begin
                     off_cof(a, c, b, dm, r.col0_re, r.col0_im, sat);
                     off_cof(conj_of(a), b, c, de, r.col1_re, r.col1_im, sat);
                     diag_cof(de, dm, a, r.col2_re, r.col2_im, sat);
                  end
               endcase
               r.eigen_index = IDX_W'(j);
               r.row_index   = row_codes[row];
               r.saturated   = sat;
               r.last        = (r.eigen_index == EIG_LAST) && (r.row_index == ROW_TAU);
               expected_rows.push_back(r);
            end
         end
      endfunction

      function void compare_field(string name, logic signed [OUT_W-1:0] want,
                                  logic signed [OUT_W-1:0] got);
         if (want !== got)
            note_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
      endfunction

      // compare one row leaving the block with the oldest prediction
      function void check_row(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_rows.size() == 0) begin
            note_mismatch($sformatf("row eig %0d row %0d with no transaction pending",
                                    got.eigen_index, got.row_index));
            return;
         end
         want = expected_rows.pop_front();
         compare_field("eigen_index", OUT_W'(want.eigen_index), OUT_W'(got.eigen_index));
         compare_field("row_index", OUT_W'(want.row_index), OUT_W'(got.row_index));
         compare_field("col0_re", want.col0_re, got.col0_re);
         compare_field("col0_im", want.col0_im, got.col0_im);
         compare_field("col1_re", want.col1_re, got.col1_re);
         compare_field("col1_im", want.col1_im, got.col1_im);
         compare_field("col2_re", want.col2_re, got.col2_re);
         compare_field("col2_im", want.col2_im, got.col2_im);
         compare_field("saturated", OUT_W'(want.saturated), OUT_W'(got.saturated));
         compare_field("last", OUT_W'(want.last), OUT_W'(got.last));
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // clock, reset and block signals
   // --------------------------------------------------------------------------
   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int long_holds_asked   = 0;
   int quiet_cycles       = 0;

   cofactor_scoreboard sb = new();

   always #1 clock = ~clock;

   hermitian_eigen_cofactors dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // --------------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------------
   function automatic logic [IN_W-1:0] random_entry(value_style_type style);
      int v;
      case (style)
         VAL_SMALL: begin
            // up to 32 units either side of zero in Q15.16
            v = int'($urandom_range(32'h003f_ffff)) - 32'sh0020_0000;
            return v;
         end
         VAL_FULL:
            return $urandom();
         VAL_EXTREME: begin
            case ($urandom_range(5))
               0: return IN_MAX;
               1: return IN_MIN;
               2: return '0;
               3: return '1;
               4: return 32'd1;
               default: return $urandom();
            endcase
         end
         default:
            return random_entry(value_style_type'($urandom_range(2)));
      endcase
   endfunction

   function automatic req_payload_type random_matrix(value_style_type style);
      logic [$bits(req_payload_type)-1:0] bits;
      for (int i = 0; i < 12; i++) bits[i*IN_W +: IN_W] = random_entry(style);
      return req_payload_type'(bits);
   endfunction

   function automatic req_payload_type uniform_matrix(logic [IN_W-1:0] v);
      return req_payload_type'({12{v}});
   endfunction

   function automatic value_style_type pick_style();
      int roll;
      roll = $urandom_range(9);
      if (roll < 5) return VAL_SMALL;
      if (roll < 8) return VAL_FULL;
      return VAL_MIXED;
   endfunction

   // offer one matrix transaction, holding it until accepted
   task automatic offer_matrix(input req_payload_type m);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and wait until every predicted row has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_rows.size() != 0) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // result side: random stall, plus long hold-off when asked
   // --------------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (holds_served != long_holds_asked) begin
            holds_served = long_holds_asked;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // --------------------------------------------------------------------------
   // monitor and watchdog
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) sb.note_matrix(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_row(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("** hermitian_eigen_cofactors: FAILED **");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin : stimulus
      req_payload_type m;
      int idle_tab[NUM_PHASES];
      int stall_tab[NUM_PHASES];
      idle_tab  = '{0, 88, 0, 15, 0};
      stall_tab = '{0, 0, 88, 15, 0};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: uniform patterns
      offer_matrix(uniform_matrix('0));
      offer_matrix(uniform_matrix(IN_MAX));
      offer_matrix(uniform_matrix(IN_MIN));
      offer_matrix(uniform_matrix(32'h5555_5555));
      offer_matrix(uniform_matrix(32'haaaa_aaaa));
      offer_matrix(uniform_matrix('1));
      offer_matrix(uniform_matrix(32'd1));

      // shifted diagonal products above the positive limit
      m = uniform_matrix('0);
      m.diag_e = IN_MAX; m.diag_mu = IN_MAX; m.diag_tau = IN_MAX;
      m.eigen_0 = IN_MIN; m.eigen_1 = IN_MIN; m.eigen_2 = IN_MAX;
      offer_matrix(m);

      // diagonal cofactor below the negative limit
      m = uniform_matrix('0);
      m.diag_mu = IN_MIN; m.diag_tau = IN_MAX;
      m.off_mutau_re = IN_MIN; m.off_mutau_im = IN_MIN;
      offer_matrix(m);

      // squared magnitudes land exactly on the negative limit
      m = uniform_matrix(IN_MIN);
      m.diag_e = '0; m.diag_mu = '0; m.diag_tau = '0;
      m.eigen_0 = '0; m.eigen_1 = '0; m.eigen_2 = '0;
      offer_matrix(m);

      // one step past the negative limit
      m.diag_mu = 32'd1; m.diag_tau = '1;
      offer_matrix(m);

      // eigenvalues equal to the diagonal give zero shifts
      m = random_matrix(VAL_SMALL);
      m.diag_e = 32'h0001_0000; m.diag_mu = 32'h0001_0000; m.diag_tau = 32'h0001_0000;
      m.eigen_0 = 32'h0001_0000; m.eigen_1 = 32'h0001_0000; m.eigen_2 = 32'h0001_0000;
      offer_matrix(m);

      // realistic values and random extremes
      offer_matrix(random_matrix(VAL_SMALL));
      offer_matrix(random_matrix(VAL_SMALL));
      repeat (10) offer_matrix(random_matrix(VAL_EXTREME));
      pause_until_drained();

      // random phases with different idle and stall mixes
      for (int p = 0; p < NUM_PHASES; p++) begin
         sender_idle_pct    = idle_tab[p];
         receiver_stall_pct = stall_tab[p];
         if (p == PRESSURE_PHASE) long_holds_asked++;
         repeat (ITEMS_PER_PHASE) offer_matrix(random_matrix(pick_style()));
         pause_until_drained();
      end

      receiver_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.expected_rows.size() == 0) begin
         $display("** hermitian_eigen_cofactors: PASSED **");
      end else begin
         $display("** hermitian_eigen_cofactors: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
